[rtl/tbp_pkg.sv]
// ----------------------------------------------------------------------------
// tbp_pkg
// Shared types, constants and counter helpers of the tournament predictor.
// ----------------------------------------------------------------------------
package tbp_pkg;

  localparam int unsigned ADDR_W           = 32;
  localparam int unsigned TALLY_W          = 32;
  localparam int unsigned CTR_W            = 2;
  localparam int unsigned INDEX_BITS_DEF   = 11;
  localparam int unsigned HISTORY_BITS_DEF = 11;
  localparam int unsigned QUEUE_DEPTH      = 4;

  typedef logic [CTR_W-1:0]   ctr_t;
  typedef logic [TALLY_W-1:0] tally_t;

  localparam ctr_t   CTR_MAX    = 2'd3;
  localparam ctr_t   TAKEN_THR  = 2'd2;
  localparam ctr_t   BIM_INIT   = 2'd3;
  localparam ctr_t   GSH_INIT   = 2'd3;
  localparam ctr_t   CHO_INIT   = 2'd0;
  localparam tally_t TALLY_MAX  = '1;

  typedef struct packed {
    logic   predicted_taken;
    logic   used_bimodal;
    logic   prediction_correct;
    tally_t correct_count;
    tally_t total_count;
  } result_t;

  // saturating step of a 2-bit counter
  function automatic ctr_t ctr_step(input ctr_t ctr, input logic up);
    ctr_t res;
    if (up) begin
      res = (ctr == CTR_MAX) ? CTR_MAX : ctr_t'(ctr + 1'b1);
    end else begin
      res = (ctr == '0) ? '0 : ctr_t'(ctr - 1'b1);
    end
    return res;
  endfunction

  function automatic logic ctr_taken(input ctr_t ctr);
    return ctr >= TAKEN_THR;
  endfunction

  function automatic tally_t tally_inc(input tally_t t, input logic en);
    return (en && t != TALLY_MAX) ? tally_t'(t + 1'b1) : t;
  endfunction

endpackage

[rtl/tbp_if.sv]
// ----------------------------------------------------------------------------
// tbp_if
// Valid/ready channels: resolved branches in, prediction results out.
// ----------------------------------------------------------------------------
interface tbp_branch_if;
  import tbp_pkg::*;

  logic              valid;
  logic              ready;
  logic [ADDR_W-1:0] branch_address;
  logic              branch_taken;

  modport source (output valid, output branch_address, output branch_taken, input ready);
  modport sink   (input valid, input branch_address, input branch_taken, output ready);
endinterface

interface tbp_result_if;
  import tbp_pkg::*;

  logic   valid;
  logic   ready;
  logic   predicted_taken;
  logic   used_bimodal;
  logic   prediction_correct;
  tally_t correct_count;
  tally_t total_count;

  modport source (output valid, output predicted_taken, output used_bimodal,
                  output prediction_correct, output correct_count, output total_count,
                  input ready);
  modport sink   (input valid, input predicted_taken, input used_bimodal,
                  input prediction_correct, input correct_count, input total_count,
                  output ready);
endinterface

[rtl/tournament_branch_predictor_top.sv]
// ----------------------------------------------------------------------------
// tournament_branch_predictor_top
// Gshare plus bimodal tournament predictor trained by resolved branches.
// ----------------------------------------------------------------------------
// Takes one resolved branch per clock and returns one result per branch, in
// order: the chosen prediction, which predictor was chosen, whether it was
// right, and saturating counts of correct and total branches. The front forms
// the table indices and shifts the global history as a branch is taken in; a
// four-entry queue feeds the back, which reads the three counter tables (the
// chooser and bimodal share a memory word; each memory has one read and one
// write port), trains them the following cycle with a one-deep bypass, and
// parks results in a two-entry buffer. Sustained rate is one branch per cycle
// while results are taken. After reset the tables are swept to their initial
// values, one entry a cycle, over all 2**INDEX_BITS entries (2048 at the
// default size); no branch is accepted during the sweep.
module tournament_branch_predictor_top #(
  parameter int unsigned INDEX_BITS   = tbp_pkg::INDEX_BITS_DEF,
  parameter int unsigned HISTORY_BITS = tbp_pkg::HISTORY_BITS_DEF
) (
  input  logic          clk,
  input  logic          rst,
  tbp_branch_if.sink    branch_in,
  tbp_result_if.source  result_out
);
  import tbp_pkg::*;

  localparam int unsigned QW = 2 * INDEX_BITS + 1;

  logic          clearing;
  logic          q_full;
  logic          q_push;
  logic [QW-1:0] q_push_data;
  logic          q_pop;
  logic          q_valid;
  logic [QW-1:0] q_head;

  tbp_front #(
    .INDEX_BITS   (INDEX_BITS),
    .HISTORY_BITS (HISTORY_BITS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .branch_in (branch_in),
    .clearing  (clearing),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_data    (q_push_data)
  );

  tbp_queue #(
    .WIDTH (QW)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_data  (q_push_data),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_valid),
    .head_data  (q_head)
  );

  tbp_back #(
    .INDEX_BITS (INDEX_BITS)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .q_valid    (q_valid),
    .q_data     (q_head),
    .q_pop      (q_pop),
    .clearing   (clearing),
    .result_out (result_out)
  );

  // no result can be waiting while the tables are being swept
  a_no_result_in_sweep: assert property (@(posedge clk) disable iff (rst)
    clearing |-> !result_out.valid)
    else $error("result pending during table sweep");

  // nothing is queued while the sweep runs
  a_queue_empty_in_sweep: assert property (@(posedge clk) disable iff (rst)
    clearing |-> !q_valid)
    else $error("queue holds a branch during table sweep");

  // an accepted branch is visible at the queue head on the next cycle
  a_accept_reaches_queue: assert property (@(posedge clk) disable iff (rst)
    (branch_in.valid && branch_in.ready) |=> q_valid)
    else $error("accepted branch missing from queue");

endmodule

[rtl/tbp_queue.sv]
// ----------------------------------------------------------------------------
// tbp_queue
// Short register queue between the front and the back of the predictor.
// ----------------------------------------------------------------------------
module tbp_queue #(
  parameter int unsigned WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic             head_valid,
  output logic [WIDTH-1:0] head_data
);
  import tbp_pkg::*;

  localparam int unsigned PtrW = $clog2(QUEUE_DEPTH);
  localparam int unsigned CntW = $clog2(QUEUE_DEPTH + 1);

  logic [WIDTH-1:0] slots [QUEUE_DEPTH];
  logic [PtrW-1:0]  wr_ptr;
  logic [PtrW-1:0]  rd_ptr;
  logic [CntW-1:0]  count;

  assign full       = (count == CntW'(QUEUE_DEPTH));
  assign head_valid = (count != '0);
  assign head_data  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= PtrW'(wr_ptr + 1'b1);
      end
      if (pop) begin
        rd_ptr <= PtrW'(rd_ptr + 1'b1);
      end
      count <= CntW'(count + CntW'(push) - CntW'(pop));
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

endmodule

[rtl/tbp_front.sv]
// ----------------------------------------------------------------------------
// tbp_front
// Accepts branches, forms the bimodal and gshare indices, keeps the history.
// ----------------------------------------------------------------------------
module tbp_front #(
  parameter int unsigned INDEX_BITS   = tbp_pkg::INDEX_BITS_DEF,
  parameter int unsigned HISTORY_BITS = tbp_pkg::HISTORY_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  tbp_branch_if.sink                  branch_in,
  input  logic                        clearing,
  input  logic                        q_full,
  output logic                        q_push,
  output logic [2*INDEX_BITS:0]       q_data
);
  import tbp_pkg::*;

  logic [HISTORY_BITS-1:0] history;
  logic [INDEX_BITS-1:0]   bim_idx;
  logic [INDEX_BITS-1:0]   gsh_idx;

  assign branch_in.ready = !q_full && !clearing;
  assign q_push          = branch_in.valid && branch_in.ready;

  // history narrower than the index is zero-extended, wider is cut
  assign bim_idx = INDEX_BITS'(branch_in.branch_address);
  assign gsh_idx = bim_idx ^ INDEX_BITS'(history);
  assign q_data  = {bim_idx, gsh_idx, branch_in.branch_taken};

  always_ff @(posedge clk) begin
    if (rst) begin
      history <= '0;
    end else if (q_push) begin
      history <= HISTORY_BITS'({history, branch_in.branch_taken});
    end
  end

endmodule

[rtl/tbp_back.sv]
// ----------------------------------------------------------------------------
// tbp_back
// Counter tables, prediction, training, tallies and the result buffer.
// ----------------------------------------------------------------------------
module tbp_back #(
  parameter int unsigned INDEX_BITS = tbp_pkg::INDEX_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  q_valid,
  input  logic [2*INDEX_BITS:0] q_data,
  output logic                  q_pop,
  output logic                  clearing,
  tbp_result_if.source          result_out
);
  import tbp_pkg::*;

  // chooser and bimodal share an index, so they share one memory word
  logic [2*CTR_W-1:0] bc_mem [2**INDEX_BITS];
  ctr_t               gs_mem [2**INDEX_BITS];

  logic [INDEX_BITS-1:0] clr_addr;

  logic [INDEX_BITS-1:0] q_bidx;
  logic [INDEX_BITS-1:0] q_gidx;

  // execute stage
  logic                  e_valid;
  logic [INDEX_BITS-1:0] e_bidx;
  logic [INDEX_BITS-1:0] e_gidx;
  logic                  e_taken;
  logic [2*CTR_W-1:0]    bc_rd;
  ctr_t                  gs_rd;

  // last table write, for a read that raced it
  logic                  fwd_valid;
  logic [INDEX_BITS-1:0] fwd_bidx;
  logic [INDEX_BITS-1:0] fwd_gidx;
  logic [2*CTR_W-1:0]    fwd_bc;
  ctr_t                  fwd_gs;

  logic [2*CTR_W-1:0] bc_cur;
  ctr_t               gs_cur;
  ctr_t               bim;
  ctr_t               cho;
  logic               bim_pred;
  logic               gsh_pred;
  logic               use_bim;
  logic               pred;
  logic               correct;
  ctr_t               cho_new;
  logic [2*CTR_W-1:0] bc_new;
  ctr_t               gs_new;

  tally_t hit_tally;
  tally_t branch_tally;
  tally_t hit_next;
  tally_t branch_next;

  logic                  bc_we;
  logic [INDEX_BITS-1:0] bc_wa;
  logic [2*CTR_W-1:0]    bc_wd;
  logic [INDEX_BITS-1:0] gs_wa;
  ctr_t                  gs_wd;

  // two-entry result buffer
  result_t     obuf [2];
  logic        o_wr;
  logic        o_rd;
  logic [1:0]  out_count;
  logic        out_pop;
  logic [1:0]  occ;

  assign {q_bidx, q_gidx} = q_data[2*INDEX_BITS:1];

  // issue only if the result buffer will have room when this item lands
  assign out_pop = result_out.valid && result_out.ready;
  assign occ     = 2'(out_count + {1'b0, e_valid} - {1'b0, out_pop});
  assign q_pop   = q_valid && !clearing && (occ <= 2'd1);

  always_comb begin
    bc_cur   = (fwd_valid && fwd_bidx == e_bidx) ? fwd_bc : bc_rd;
    gs_cur   = (fwd_valid && fwd_gidx == e_gidx) ? fwd_gs : gs_rd;
    cho      = bc_cur[2*CTR_W-1:CTR_W];
    bim      = bc_cur[CTR_W-1:0];
    bim_pred = ctr_taken(bim);
    gsh_pred = ctr_taken(gs_cur);
    use_bim  = ctr_taken(cho);
    pred     = use_bim ? bim_pred : gsh_pred;
    correct  = (pred == e_taken);
    cho_new  = (bim_pred != gsh_pred) ? ctr_step(cho, bim_pred == e_taken) : cho;
    bc_new   = {cho_new, ctr_step(bim, e_taken)};
    gs_new   = ctr_step(gs_cur, e_taken);
    hit_next    = tally_inc(hit_tally, correct);
    branch_next = tally_inc(branch_tally, 1'b1);
  end

  always_comb begin
    bc_we = clearing || e_valid;
    if (clearing) begin
      bc_wa = clr_addr;
      bc_wd = {CHO_INIT, BIM_INIT};
      gs_wa = clr_addr;
      gs_wd = GSH_INIT;
    end else begin
      bc_wa = e_bidx;
      bc_wd = bc_new;
      gs_wa = e_gidx;
      gs_wd = gs_new;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      bc_rd <= bc_mem[q_bidx];
      gs_rd <= gs_mem[q_gidx];
    end
    if (bc_we) begin
      bc_mem[bc_wa] <= bc_wd;
      gs_mem[gs_wa] <= gs_wd;
    end
  end

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      clearing     <= 1'b1;
      clr_addr     <= '0;
      e_valid      <= 1'b0;
      fwd_valid    <= 1'b0;
      hit_tally    <= '0;
      branch_tally <= '0;
      out_count    <= '0;
      o_wr         <= 1'b0;
      o_rd         <= 1'b0;
    end else begin
      if (clearing) begin
        clr_addr <= INDEX_BITS'(clr_addr + 1'b1);
        if (&clr_addr) begin
          clearing <= 1'b0;
        end
      end
      e_valid   <= q_pop;
      fwd_valid <= e_valid;
      if (e_valid) begin
        hit_tally    <= hit_next;
        branch_tally <= branch_next;
        o_wr         <= ~o_wr;
      end
      if (out_pop) begin
        o_rd <= ~o_rd;
      end
      out_count <= 2'(out_count + {1'b0, e_valid} - {1'b0, out_pop});
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (q_pop) begin
      e_bidx  <= q_bidx;
      e_gidx  <= q_gidx;
      e_taken <= q_data[0];
    end
    if (e_valid) begin
      fwd_bidx   <= e_bidx;
      fwd_gidx   <= e_gidx;
      fwd_bc     <= bc_new;
      fwd_gs     <= gs_new;
      obuf[o_wr] <= '{predicted_taken:    pred,
                      used_bimodal:       use_bim,
                      prediction_correct: correct,
                      correct_count:      hit_next,
                      total_count:        branch_next};
    end
  end

  assign result_out.valid              = (out_count != '0);
  assign result_out.predicted_taken    = obuf[o_rd].predicted_taken;
  assign result_out.used_bimodal       = obuf[o_rd].used_bimodal;
  assign result_out.prediction_correct = obuf[o_rd].prediction_correct;
  assign result_out.correct_count      = obuf[o_rd].correct_count;
  assign result_out.total_count        = obuf[o_rd].total_count;

endmodule

[verif/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the tournament branch predictor.
// ----------------------------------------------------------------------------
// Resolved branches go in on the valid/ready input channel. A cycle-free
// model keeps its own bimodal, gshare and chooser tables, global history and
// tallies, and works out the result of every accepted branch. Each transfer
// on the result channel is checked in order against the oldest expectation.
// Traffic moves through three idling mixes. Two long receiver hold-offs fill
// the block, and the sender pauses once until every result is back.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import tbp_pkg::*;

  localparam int unsigned IDX_W        = INDEX_BITS_DEF;
  localparam int unsigned HIST_W       = HISTORY_BITS_DEF;
  localparam int unsigned ITEM_COUNT   = 1300;
  localparam int unsigned HOT_COUNT    = 24;
  localparam int unsigned HOLD_CYCLES  = 300;
  localparam int unsigned DRAIN_CYCLES = 20;
  localparam int unsigned CYCLE_LIMIT  = 400000;

  typedef enum logic [1:0] {
    MOSTLY_TAKEN,
    MOSTLY_NOT_TAKEN,
    LOOP_EXIT,
    FOLLOWS_LAST
  } habit_e;

  class prediction_scoreboard;
    typedef logic [IDX_W-1:0]  idx_t;
    typedef logic [HIST_W-1:0] hist_t;

    ctr_t    bim_tab [2**IDX_W];
    ctr_t    gsh_tab [2**IDX_W];
    ctr_t    cho_tab [2**IDX_W];
    hist_t   history;
    tally_t  hits;
    tally_t  branches;
    result_t pending_predictions [$];
    int      fails;

    function new();
      foreach (bim_tab[i]) begin
        bim_tab[i] = BIM_INIT;
        gsh_tab[i] = GSH_INIT;
        cho_tab[i] = CHO_INIT;
      end
      history  = '0;
      hits     = '0;
      branches = '0;
      fails    = 0;
    endfunction

    function ctr_t nudge(ctr_t c, logic up);
      if (up) begin
        return (c == CTR_MAX) ? c : ctr_t'(c + 1'b1);
      end
      return (c == 2'd0) ? c : ctr_t'(c - 1'b1);
    endfunction

    function void note_branch(logic [ADDR_W-1:0] addr, logic taken);
      idx_t    a_idx;
      idx_t    g_idx;
      logic    bim_says;
      logic    gsh_says;
      logic    pick_bim;
      logic    guess;
      result_t want;
      a_idx    = addr[IDX_W-1:0];
      g_idx    = a_idx ^ idx_t'(history);
      bim_says = bim_tab[a_idx] >= TAKEN_THR;
      gsh_says = gsh_tab[g_idx] >= TAKEN_THR;
      pick_bim = cho_tab[a_idx] >= TAKEN_THR;
      guess    = pick_bim ? bim_says : gsh_says;
      // chooser only moves when the two disagree
      if (bim_says != gsh_says) begin
        cho_tab[a_idx] = nudge(cho_tab[a_idx], bim_says == taken);
      end
      gsh_tab[g_idx] = nudge(gsh_tab[g_idx], taken);
      bim_tab[a_idx] = nudge(bim_tab[a_idx], taken);
      history = {history[HIST_W-2:0], taken};
      if (guess == taken && hits != TALLY_MAX) begin
        hits = hits + 1'b1;
      end
      if (branches != TALLY_MAX) begin
        branches = branches + 1'b1;
      end
      want.predicted_taken    = guess;
      want.used_bimodal       = pick_bim;
      want.prediction_correct = (guess == taken);
      want.correct_count      = hits;
      want.total_count        = branches;
      pending_predictions.push_back(want);
    endfunction

    function void compare_field(string name, tally_t want, tally_t got);
      if (want !== got) begin
        $display("%0t: %s mismatch: expected %0h actual %0h", $time, name, want, got);
        fails++;
      end
    endfunction

    function void check_result(result_t got);
      result_t want;
      if (pending_predictions.size() == 0) begin
        $display("%0t: result transfer with nothing expected: actual %h", $time, got);
        fails++;
      end else begin
        want = pending_predictions.pop_front();
        compare_field("predicted_taken", tally_t'(want.predicted_taken),
                      tally_t'(got.predicted_taken));
        compare_field("used_bimodal", tally_t'(want.used_bimodal),
                      tally_t'(got.used_bimodal));
        compare_field("prediction_correct", tally_t'(want.prediction_correct),
                      tally_t'(got.prediction_correct));
        compare_field("correct_count", want.correct_count, got.correct_count);
        compare_field("total_count", want.total_count, got.total_count);
      end
    endfunction

    function int pending();
      return pending_predictions.size();
    endfunction
  endclass

  logic clk;
  logic rst;

  tbp_branch_if branch_ch();
  tbp_result_if result_ch();

  tournament_branch_predictor_top dut (
    .clk        (clk),
    .rst        (rst),
    .branch_in  (branch_ch),
    .result_out (result_ch)
  );

  prediction_scoreboard predictions = new();

  int                send_idle_pct;
  int                recv_idle_pct;
  int unsigned       cycle_count  = 0;
  int unsigned       results_seen = 0;
  int unsigned       hold_left    = 0;
  logic [ADDR_W-1:0] hot_addr   [HOT_COUNT];
  habit_e            hot_habit  [HOT_COUNT];
  int unsigned       hot_period [HOT_COUNT];
  int unsigned       hot_trip   [HOT_COUNT];
  logic              last_outcome;

  initial clk = 1'b0;
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // result side: check each transfer, then pick ready for the next edge
  always @(posedge clk) begin : result_sink
    result_t got;
    if (rst) begin
      result_ch.ready <= 1'b0;
    end else begin
      if (result_ch.valid && result_ch.ready) begin
        got.predicted_taken    = result_ch.predicted_taken;
        got.used_bimodal       = result_ch.used_bimodal;
        got.prediction_correct = result_ch.prediction_correct;
        got.correct_count      = result_ch.correct_count;
        got.total_count        = result_ch.total_count;
        predictions.check_result(got);
        results_seen++;
        // long hold-off so the input queue fills and back-pressures the sender
        if (results_seen == 200 || results_seen == 1000) begin
          hold_left = HOLD_CYCLES;
        end
      end
      if (hold_left != 0) begin
        hold_left--;
        result_ch.ready <= 1'b0;
      end else begin
        result_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  task automatic send_branch(input logic [ADDR_W-1:0] addr, input logic taken);
    while ($urandom_range(99) < send_idle_pct) begin
      branch_ch.valid <= 1'b0;
      @(posedge clk);
    end
    branch_ch.valid          <= 1'b1;
    branch_ch.branch_address <= addr;
    branch_ch.branch_taken   <= taken;
    do @(posedge clk); while (!branch_ch.ready);
    predictions.note_branch(addr, taken);
  endtask

  task automatic wait_for_drain();
    branch_ch.valid <= 1'b0;
    @(posedge clk);
    while (predictions.pending() != 0) begin
      @(posedge clk);
    end
  endtask

  // mostly well-behaved hot branches, the rest random noise
  task automatic make_branch(output logic [ADDR_W-1:0] addr, output logic taken);
    int unsigned k;
    if ($urandom_range(99) < 30) begin
      addr  = $urandom;
      taken = 1'($urandom_range(1));
    end else begin
      k    = $urandom_range(HOT_COUNT - 1);
      addr = hot_addr[k];
      // same table entry reached through different upper address bits
      if ($urandom_range(9) == 0) begin
        addr[ADDR_W-1:IDX_W] = (ADDR_W-IDX_W)'($urandom);
      end
      case (hot_habit[k])
        MOSTLY_TAKEN: begin
          taken = ($urandom_range(99) < 90);
        end
        MOSTLY_NOT_TAKEN: begin
          taken = ($urandom_range(99) < 10);
        end
        LOOP_EXIT: begin
          hot_trip[k]++;
          taken = (hot_trip[k] % hot_period[k]) != 0;
        end
        default: begin
          taken = last_outcome ^ ($urandom_range(19) == 0);
        end
      endcase
    end
    last_outcome = taken;
  endtask

  initial begin : stimulus
    logic [ADDR_W-1:0] addr;
    logic              taken;
    rst                      = 1'b1;
    branch_ch.valid          = 1'b0;
    branch_ch.branch_address = '0;
    branch_ch.branch_taken   = 1'b0;
    send_idle_pct            = 19;
    recv_idle_pct            = 82;
    last_outcome             = 1'b0;
    for (int k = 0; k < HOT_COUNT; k++) begin
      hot_addr[k]   = $urandom;
      hot_habit[k]  = habit_e'($urandom_range(3));
      hot_period[k] = $urandom_range(2, 8);
      hot_trip[k]   = 0;
    end
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // address extremes and aliasing through the ignored upper bits
    send_branch(32'h0000_0000, 1'b0);
    send_branch(32'hFFFF_FFFF, 1'b1);
    send_branch(32'h0000_07FF, 1'b0);
    send_branch(32'hFFFF_F800, 1'b1);
    send_branch(32'h8000_0000, 1'b0);
    // repeated not-taken pulls bimodal down while history moves gshare to
    // fresh entries, so the two disagree and the chooser steps
    send_branch(32'h0000_0010, 1'b0);
    send_branch(32'h0000_0010, 1'b0);
    send_branch(32'h0000_0010, 1'b0);
    send_branch(32'h0000_0005, 1'b1);
    send_branch(32'h0000_0010, 1'b0);
    send_branch(32'h0000_0010, 1'b0);
    send_branch(32'h0000_0010, 1'b1);
    send_branch(32'h0000_0010, 1'b1);
    send_branch(32'h0000_0010, 1'b1);
    send_branch(32'hAAAA_AAAA, 1'b1);
    send_branch(32'h5555_5555, 1'b0);
    send_branch(32'h0000_07FF, 1'b1);
    send_branch(32'h0000_07FF, 1'b1);

    for (int n = 0; n < ITEM_COUNT; n++) begin
      if (n == ITEM_COUNT / 3) begin
        wait_for_drain();
        send_idle_pct = 82;
        recv_idle_pct = 19;
      end
      if (n == 2 * ITEM_COUNT / 3) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      make_branch(addr, taken);
      send_branch(addr, taken);
    end

    wait_for_drain();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (predictions.fails == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
